@@ hw/rtl/uitp_pkg.sv @@
// uitp_pkg: shared types and constants of the unsigned integer text parser
// used by uitp_front, uitp_queue, uitp_back and the top level
// no dependencies
`default_nettype none

package uitp_pkg;

    // character and base widths fixed by the interface
    localparam int CHAR_W = 8;
    localparam int BASE_W = 6;

    // characters the classifier looks for
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;
    localparam logic [CHAR_W-1:0] LOW_NIB  = 8'h0f;
    // 'A' minus ten, so an upper-case letter maps to 10..35
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'h37;

    // bases that the prefix logic cares about
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    // one classified character as it travels from front to back
    typedef struct packed {
        logic              start;
        logic              is_space;
        logic              is_plus;
        logic              is_minus;
        logic              is_zero;
        logic              is_x;
        logic              is_digit;
        logic [BASE_W-1:0] dig;
    } cls_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/uitp_front.sv @@
// uitp_front: input handshake and character classification
// depends on uitp_pkg
`default_nettype none

module uitp_front
(
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [uitp_pkg::CHAR_W-1:0]  char_byte,
    input  wire logic                         start_req,
    input  wire uitp_pkg::q_stat_t            q_stat,
    output logic                              push,
    output uitp_pkg::cls_t                    cls
);

    logic [uitp_pkg::CHAR_W-1:0] upper;
    logic [uitp_pkg::CHAR_W-1:0] letter_val;
    logic [uitp_pkg::CHAR_W-1:0] num_val;

    // accept a beat whenever the queue has room
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // classify the character
    always_comb
    begin
        upper      = char_byte & ~uitp_pkg::CASE_BIT;
        letter_val = upper - uitp_pkg::LETTER_OFS;
        num_val    = char_byte & uitp_pkg::LOW_NIB;

        cls.start    = start_req;
        cls.is_space = (char_byte inside {[uitp_pkg::CH_TAB:uitp_pkg::CH_CR],
                                          uitp_pkg::CH_SPACE});
        cls.is_plus  = (char_byte == uitp_pkg::CH_PLUS);
        cls.is_minus = (char_byte == uitp_pkg::CH_MINUS);
        cls.is_zero  = (char_byte == uitp_pkg::CH_ZERO);
        cls.is_x     = ((char_byte | uitp_pkg::CASE_BIT) == uitp_pkg::CH_LO_X);
        cls.is_digit = 1'b0;
        cls.dig      = '0;
        if (char_byte inside {[uitp_pkg::CH_ZERO:uitp_pkg::CH_NINE]})
        begin
            cls.is_digit = 1'b1;
            cls.dig      = num_val[uitp_pkg::BASE_W-1:0];
        end
        else if (char_byte inside {[uitp_pkg::CH_UP_A:uitp_pkg::CH_UP_Z],
                                   [uitp_pkg::CH_LO_A:uitp_pkg::CH_LO_Z]})
        begin
            cls.is_digit = 1'b1;
            cls.dig      = letter_val[uitp_pkg::BASE_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/uitp_queue.sv @@
// uitp_queue: two-entry queue of classified characters between front and back
// depends on uitp_pkg
`default_nettype none

module uitp_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire uitp_pkg::cls_t     wr_data,
    input  wire logic               pop,
    output uitp_pkg::cls_t          rd_data,
    output uitp_pkg::q_stat_t       q_stat
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    uitp_pkg::cls_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign rd_data      = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/uitp_back.sv @@
// uitp_back: parse state machine, accumulate and overflow check, output register
// depends on uitp_pkg
`default_nettype none

module uitp_back
#(
    parameter int VALUE_BITS  = 32,
    parameter int OFFSET_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire uitp_pkg::q_stat_t           q_stat,
    input  wire uitp_pkg::cls_t              cls,
    output logic                             pop,
    input  wire logic [uitp_pkg::BASE_W-1:0] cfg_base,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             done_res,
    output logic [VALUE_BITS-1:0]            value,
    output logic [OFFSET_BITS-1:0]           end_offset,
    output logic                             saturated
);

    localparam int BW = uitp_pkg::BASE_W;
    localparam int MW = VALUE_BITS + BW + 1;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SPACE  = 5'b00010,
        PH_SIGNED = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } phase_t;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    phase_t                 phase_cur;
    logic                   neg_reg;
    logic                   neg_next;
    logic                   neg_cur;
    logic [BW-1:0]          base_reg;
    logic [BW-1:0]          base_next;
    logic [BW-1:0]          base_cur;
    logic [VALUE_BITS-1:0]  acc_reg;
    logic [VALUE_BITS-1:0]  acc_next;
    logic [VALUE_BITS-1:0]  acc_cur;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [OFFSET_BITS-1:0] pos_cur;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   done_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   sat_reg;

    logic                   chk_signed;
    logic                   chk_zero;
    logic                   chk_digit;
    logic                   adv;
    logic                   fin;
    logic                   fin_sat;
    logic                   auto_or_hex;
    logic [BW-1:0]          dig_base;
    logic [MW-1:0]          mac;
    logic                   ovf;
    logic [VALUE_BITS-1:0]  fin_val;

    // take a beat from the queue when the output register is free
    assign pop = !q_stat.empty && (!out_valid_reg || !out_stall);

    // a start beat restarts the parse from the configured base
    always_comb
    begin
        phase_cur = cls.start ? PH_SPACE : phase_reg;
        neg_cur   = cls.start ? 1'b0 : neg_reg;
        base_cur  = cls.start ? cfg_base : base_reg;
        acc_cur   = cls.start ? '0 : acc_reg;
        pos_cur   = cls.start ? '0 : pos_reg;
    end

    // base a digit is checked against, auto base resolved by phase
    always_comb
    begin
        dig_base = base_cur;
        if ((base_cur == uitp_pkg::BASE_AUTO) && (phase_cur == PH_ZERO))
        begin
            dig_base = uitp_pkg::BASE_OCT;
        end
        else if ((base_cur == uitp_pkg::BASE_AUTO) && (phase_cur != PH_DIGITS))
        begin
            dig_base = uitp_pkg::BASE_DEC;
        end
    end

    // multiply-accumulate and overflow test
    assign mac = MW'(acc_cur) * MW'(dig_base) + MW'(cls.dig);
    assign ovf = |mac[MW-1:VALUE_BITS];

    // phase walk for one character
    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        chk_signed  = 1'b0;
        chk_zero    = 1'b0;
        chk_digit   = 1'b0;
        adv         = 1'b0;
        fin         = 1'b0;
        fin_sat     = 1'b0;
        auto_or_hex = 1'b0;
        if (pop)
        begin
            phase_next = phase_cur;
            neg_next   = neg_cur;
            base_next  = base_cur;
            acc_next   = acc_cur;
            auto_or_hex = (base_cur == uitp_pkg::BASE_AUTO) ||
                          (base_cur == uitp_pkg::BASE_HEX);
            case (phase_cur)
                PH_SPACE:
                begin
                    if (cls.is_space)
                    begin
                        adv = 1'b1;
                    end
                    else if (cls.is_plus || cls.is_minus)
                    begin
                        neg_next   = cls.is_minus;
                        adv        = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else
                    begin
                        chk_signed = 1'b1;
                    end
                end
                PH_SIGNED: chk_signed = 1'b1;
                PH_ZERO:   chk_zero   = 1'b1;
                PH_DIGITS: chk_digit  = 1'b1;
                default:   ;
            endcase

            // optional leading zero
            if (chk_signed)
            begin
                if (cls.is_zero && auto_or_hex)
                begin
                    adv        = 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    if (base_cur == uitp_pkg::BASE_AUTO)
                    begin
                        base_next = uitp_pkg::BASE_DEC;
                    end
                    chk_digit = 1'b1;
                end
            end

            // hex prefix after the zero
            if (chk_zero)
            begin
                if (cls.is_x && auto_or_hex)
                begin
                    base_next  = uitp_pkg::BASE_HEX;
                    adv        = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    if (base_cur == uitp_pkg::BASE_AUTO)
                    begin
                        base_next = uitp_pkg::BASE_OCT;
                    end
                    chk_digit = 1'b1;
                end
            end

            // digit accumulate or stop
            if (chk_digit)
            begin
                if (!cls.is_digit || (base_next == uitp_pkg::BASE_AUTO) ||
                    (cls.dig >= base_next))
                begin
                    fin = 1'b1;
                end
                else if (ovf)
                begin
                    fin     = 1'b1;
                    fin_sat = 1'b1;
                end
                else
                begin
                    acc_next   = mac[VALUE_BITS-1:0];
                    adv        = 1'b1;
                    phase_next = PH_DIGITS;
                end
            end

            if (fin)
            begin
                phase_next = PH_IDLE;
            end

            // offset counts up and sticks at its maximum
            pos_next = (adv && (pos_cur != '1)) ? pos_cur + 1'b1 : pos_cur;
        end
    end

    // final value, clamped and negated as needed
    always_comb
    begin
        fin_val = fin_sat ? '1 : acc_cur;
        if (neg_cur)
        begin
            fin_val = '0 - fin_val;
        end
    end

    assign out_valid_next = pop ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            neg_reg       <= 1'b0;
            base_reg      <= '0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            done_reg   <= fin;
            value_reg  <= fin ? fin_val : '0;
            offset_reg <= fin ? pos_cur : '0;
            sat_reg    <= fin_sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign done_res   = done_reg;
    assign value      = value_reg;
    assign end_offset = offset_reg;
    assign saturated  = sat_reg;

endmodule

`default_nettype wire

@@ hw/rtl/unsigned_integer_text_parser_unit.sv @@
// Streaming unsigned integer parser, one character per input beat.
//
// Input channel (in_valid / in_stall): char_byte and start_req. start_req
// marks the first character of a string and loads the base from default_base;
// past white space, sign and prefix, a NUL or any non-digit ends the parse.
// Output channel (out_valid / out_stall): exactly one beat per input beat,
// in order. done_res is 1 on the beat of the character that ended the
// parse, with value, end_offset and saturated; otherwise all fields are 0.
// Config channel (cfg_valid / cfg_ready): writes default_base, always ready;
// write it only while no beats are in flight.
// Each character's beat passes through the queue and the output register.
// Throughput: one character per cycle while out_stall is low; multiply-by-base
// and overflow check in the back end are combinational. A two-entry queue
// sits between classifier and parser, so input stalls only once it is full.
// Reset clears the queue, the output valid flag and the parse state; the
// parser then ignores characters until a start beat arrives.
// While out_stall is high the output beat holds and the queue fills.
//
// depends on uitp_pkg, uitp_front, uitp_queue, uitp_back
`default_nettype none

module unsigned_integer_text_parser_unit
#(
    parameter int VALUE_BITS  = 32,
    parameter int OFFSET_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [uitp_pkg::CHAR_W-1:0] char_byte,
    input  wire logic                        start_req,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             done_res,
    output logic [VALUE_BITS-1:0]            value,
    output logic [OFFSET_BITS-1:0]           end_offset,
    output logic                             saturated,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [uitp_pkg::BASE_W-1:0] default_base
);

    logic [uitp_pkg::BASE_W-1:0] base_cfg_reg;
    logic [uitp_pkg::BASE_W-1:0] base_cfg_next;
    uitp_pkg::q_stat_t           q_stat;
    uitp_pkg::cls_t              cls_in;
    uitp_pkg::cls_t              cls_out;
    logic                        push;
    logic                        pop;

    // configuration register
    assign cfg_ready     = 1'b1;
    assign base_cfg_next = (cfg_valid && cfg_ready) ? default_base : base_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg <= '0;
        end
        else
        begin
            base_cfg_reg <= base_cfg_next;
        end
    end

    // front: handshake and classify
    uitp_front u_front
    (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_byte (char_byte),
        .start_req (start_req),
        .q_stat    (q_stat),
        .push      (push),
        .cls       (cls_in)
    );

    // queue between front and back
    uitp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cls_in),
        .pop     (pop),
        .rd_data (cls_out),
        .q_stat  (q_stat)
    );

    // back: parse and produce result beats
    uitp_back
    #(
        .VALUE_BITS  (VALUE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .cls        (cls_out),
        .pop        (pop),
        .cfg_base   (base_cfg_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .done_res   (done_res),
        .value      (value),
        .end_offset (end_offset),
        .saturated  (saturated)
    );

    // a running beat carries all-zero fields
    a_running_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (value == '0 && end_offset == '0 && !saturated))
        else $error("running beat with nonzero fields");

    // a clamped value is all ones, or one after negation
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (done_res && (value == '1 || value == VALUE_BITS'(1))))
        else $error("saturated beat with bad value");

    // back never pops an empty queue and front never pushes a full one
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty) && !(push && q_stat.full))
        else $error("queue under or overflow");

    // every popped beat shows up on the output the next cycle
    a_pop_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("popped beat lost");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for unsigned_integer_text_parser_unit: directed and random character
// streams, each result beat checked against an in-bench strtoul-style parse model
// depends on uitp_pkg and the unsigned_integer_text_parser_unit rtl
`timescale 1ns / 100ps

module tb_top;

    localparam int VALUE_BITS  = 32;
    localparam int OFFSET_BITS = 16;
    localparam int WD_LIMIT    = 3000;
    localparam int HOLD_CYCLES = 150;
    localparam int END_CYCLES  = 10;
    localparam logic [63:0] VAL_MASK = 64'hffff_ffff;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [uitp_pkg::CHAR_W-1:0] CH_NUL = 8'h00;

    // parse phases of the model
    typedef enum logic [2:0] {
        PS_IDLE,
        PS_SPACE,
        PS_SIGNED,
        PS_ZERO,
        PS_DIGITS
    } parse_phase_t;

    // one result beat
    typedef struct packed {
        logic                   done;
        logic [VALUE_BITS-1:0]  val;
        logic [OFFSET_BITS-1:0] offs;
        logic                   sat;
    } parse_res_t;

    // dut signals, inputs driven to known values from time zero
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [uitp_pkg::CHAR_W-1:0]   char_byte = '0;
    logic                          start_req = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          done_res;
    logic [VALUE_BITS-1:0]         value;
    logic [OFFSET_BITS-1:0]        end_offset;
    logic                          saturated;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [uitp_pkg::BASE_W-1:0]   default_base = '0;

    // model state
    logic [uitp_pkg::BASE_W-1:0]   cfg_base = uitp_pkg::BASE_AUTO;
    parse_phase_t                  ph_q = PS_IDLE;
    logic                          neg_q = 1'b0;
    logic [uitp_pkg::BASE_W-1:0]   run_base = '0;
    logic [VALUE_BITS-1:0]         acc_q = '0;
    logic [OFFSET_BITS-1:0]        pos_q = '0;

    parse_res_t             pending_res[$];
    parse_res_t             head_res;
    int                     err_cnt = 0;
    int                     tx_idle_pct = 24;
    int                     rx_idle_pct = 24;
    int                     hold_req = 0;
    int                     hold_ack = 0;
    int                     hold_left = 0;
    int                     quiet_cycles = 0;

    unsigned_integer_text_parser_unit #(
        .VALUE_BITS  (VALUE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_byte    (char_byte),
        .start_req    (start_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .done_res     (done_res),
        .value        (value),
        .end_offset   (end_offset),
        .saturated    (saturated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .default_base (default_base)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // parse model
    // ---------------------------------------------------------------

    // consumed characters, saturating
    function automatic void bump_pos();
        if (pos_q != POS_MAX)
            pos_q = pos_q + 1'b1;
    endfunction

    // final beat of a parse
    function automatic parse_res_t close_parse(input logic sat);
        parse_res_t r;
        logic [VALUE_BITS-1:0] v;
        v = sat ? '1 : acc_q;
        if (neg_q)
            v = -v;
        r.done = 1'b1;
        r.val  = v;
        r.offs = pos_q;
        r.sat  = sat;
        ph_q   = PS_IDLE;
        return r;
    endfunction

    // advance the model by one character, return the beat it yields
    function automatic parse_res_t parse_char(input logic [uitp_pkg::CHAR_W-1:0] c,
                                              input logic s);
        parse_res_t r;
        logic [63:0] d;
        logic auto_or_hex;
        r = '0;
        if (s)
        begin
            neg_q    = 1'b0;
            acc_q    = '0;
            pos_q    = '0;
            run_base = cfg_base;
            ph_q     = PS_SPACE;
        end
        if (ph_q == PS_IDLE)
            return r;

        // leading white space and sign
        if (ph_q == PS_SPACE)
        begin
            if (c == uitp_pkg::CH_SPACE || (c >= uitp_pkg::CH_TAB && c <= uitp_pkg::CH_CR))
            begin
                bump_pos();
                return r;
            end
            if (c == uitp_pkg::CH_PLUS || c == uitp_pkg::CH_MINUS)
            begin
                neg_q = (c == uitp_pkg::CH_MINUS);
                bump_pos();
                ph_q = PS_SIGNED;
                return r;
            end
            ph_q = PS_SIGNED;
        end

        // prefix detection
        auto_or_hex = (run_base == uitp_pkg::BASE_AUTO) || (run_base == uitp_pkg::BASE_HEX);
        if (ph_q == PS_SIGNED)
        begin
            if (c == uitp_pkg::CH_ZERO && auto_or_hex)
            begin
                bump_pos();
                ph_q = PS_ZERO;
                return r;
            end
            if (run_base == uitp_pkg::BASE_AUTO)
                run_base = uitp_pkg::BASE_DEC;
            ph_q = PS_DIGITS;
        end
        else if (ph_q == PS_ZERO)
        begin
            if ((c | uitp_pkg::CASE_BIT) == uitp_pkg::CH_LO_X && auto_or_hex)
            begin
                run_base = uitp_pkg::BASE_HEX;
                bump_pos();
                ph_q = PS_DIGITS;
                return r;
            end
            if (run_base == uitp_pkg::BASE_AUTO)
                run_base = uitp_pkg::BASE_OCT;
            ph_q = PS_DIGITS;
        end

        // digit accumulation
        if (c >= uitp_pkg::CH_ZERO && c <= uitp_pkg::CH_NINE)
            d = 64'(c & uitp_pkg::LOW_NIB);
        else if ((c >= uitp_pkg::CH_UP_A && c <= uitp_pkg::CH_UP_Z) ||
                 (c >= uitp_pkg::CH_LO_A && c <= uitp_pkg::CH_LO_Z))
            d = 64'(c & ~uitp_pkg::CASE_BIT) - 64'(uitp_pkg::LETTER_OFS);
        else
            return close_parse(1'b0);
        if (run_base == '0 || d >= 64'(run_base))
            return close_parse(1'b0);
        if (64'(acc_q) > (VAL_MASK - d) / 64'(run_base))
            return close_parse(1'b1);
        acc_q = VALUE_BITS'(64'(acc_q) * 64'(run_base) + d);
        bump_pos();
        return r;
    endfunction

    // ---------------------------------------------------------------
    // receiver side and result check
    // ---------------------------------------------------------------

    // out_stall: random idling plus requested long hold-offs
    always @(negedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_res.size() == 0)
                report_mismatch("unexpected result beat, done_res", 64'(done_res), 64'd0);
            else
            begin
                head_res = pending_res.pop_front();
                if (done_res !== head_res.done)
                    report_mismatch("done_res", 64'(done_res), 64'(head_res.done));
                if (value !== head_res.val)
                    report_mismatch("value", 64'(value), 64'(head_res.val));
                if (end_offset !== head_res.offs)
                    report_mismatch("end_offset", 64'(end_offset), 64'(head_res.offs));
                if (saturated !== head_res.sat)
                    report_mismatch("saturated", 64'(saturated), 64'(head_res.sat));
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("unsigned_integer_text_parser_unit: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sender side; every task is entered and left at a falling edge
    // ---------------------------------------------------------------

    // one character beat, with random idle cycles ahead of it
    task automatic send_char(input logic [uitp_pkg::CHAR_W-1:0] c, input logic s);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= c;
        start_req <= s;
        do
            @(posedge clk);
        while (in_stall);
        pending_res.push_back(parse_char(c, s));
        @(negedge clk);
    endtask

    // a string, start on its first character
    task automatic send_str(input string str);
        for (int i = 0; i < str.len(); i++)
            send_char(str[i], i == 0);
    endtask

    // stop offering and let every expected beat arrive
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    // default_base write, only while drained
    task automatic write_base(input logic [uitp_pkg::BASE_W-1:0] b);
        wait_drained();
        cfg_valid    <= 1'b1;
        default_base <= b;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_base = b;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [uitp_pkg::CHAR_W-1:0] rand_space();
        int v;
        v = $urandom_range(5, 0);
        return (v == 0) ? uitp_pkg::CH_SPACE : uitp_pkg::CH_TAB + uitp_pkg::CHAR_W'(v - 1);
    endfunction

    // a digit or letter below base b, random case
    function automatic logic [uitp_pkg::CHAR_W-1:0] rand_digit(input int b);
        int span;
        int v;
        span = (b > 36) ? 36 : ((b < 1) ? 10 : b);
        v = $urandom_range(span - 1, 0);
        if (v < 10)
            return uitp_pkg::CH_ZERO + uitp_pkg::CHAR_W'(v);
        return ($urandom_range(1, 0) ? uitp_pkg::CH_LO_A : uitp_pkg::CH_UP_A) +
               uitp_pkg::CHAR_W'(v - 10);
    endfunction

    // well-formed number text with random content, sometimes left unterminated
    task automatic send_word(input int b, inout int sent);
        logic st;
        int   eb;
        int   nsp;
        int   ndig;
        int   kind;
        st  = 1'b1;
        eb  = (b == 0) ? 10 : b;
        nsp = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
        repeat (nsp)
        begin
            send_char(rand_space(), st);
            st = 1'b0;
            sent++;
        end
        kind = $urandom_range(3, 0);
        if (kind < 2)
        begin
            send_char((kind == 0) ? uitp_pkg::CH_PLUS : uitp_pkg::CH_MINUS, st);
            st = 1'b0;
            sent++;
        end
        if ((b == 0 || b == 16) && $urandom_range(2, 0) == 0)
        begin
            send_char(uitp_pkg::CH_ZERO, st);
            send_char($urandom_range(1, 0) ? uitp_pkg::CH_LO_X :
                      (uitp_pkg::CH_LO_X & ~uitp_pkg::CASE_BIT), 1'b0);
            st = 1'b0;
            sent += 2;
            eb = 16;
        end
        else if (b == 0 && $urandom_range(3, 0) == 0)
        begin
            send_char(uitp_pkg::CH_ZERO, st);
            st = 1'b0;
            sent++;
            eb = 8;
        end
        ndig = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 8) : $urandom_range(7, 0);
        repeat (ndig)
        begin
            send_char(rand_digit(eb), st);
            st = 1'b0;
            sent++;
        end
        // terminator, or none so that the next start restarts mid-parse
        if ($urandom_range(6, 0) != 0)
        begin
            case ($urandom_range(3, 0))
                0: send_char(CH_NUL, st);
                1: send_char(rand_space(), st);
                2: send_char(uitp_pkg::CHAR_W'($urandom_range(255, 0)), st);
                default: send_char(8'h80 | uitp_pkg::CHAR_W'($urandom_range(127, 0)), st);
            endcase
            sent++;
        end
    endtask

    // random bytes, mostly without start
    task automatic send_noise();
        repeat ($urandom_range(6, 1))
            send_char(uitp_pkg::CHAR_W'($urandom_range(255, 0)), $urandom_range(5, 0) == 0);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // characters before any start are ignored
    task automatic test_idle_start();
        send_char(8'h37, 1'b0);
        send_char(8'hff, 1'b0);
    endtask

    // automatic base: hex, octal, decimal, bare prefix, no digits, restart
    task automatic test_auto_base();
        write_base(uitp_pkg::BASE_AUTO);
        send_str(" -0x1F");
        send_char(CH_NUL, 1'b0);
        send_str("0X");
        send_char(CH_NUL, 1'b0);
        send_str("0179");
        send_str("\t+");
        send_char(CH_NUL, 1'b0);
        send_str("12");
        send_str("5");
        send_char(8'hb0, 1'b0);
    endtask

    // overflow saturation, with and without minus
    task automatic test_overflow();
        write_base(6'd36);
        send_str("-zzzzzzz");
        send_str("ZZZZZZZ!");
    endtask

    // base 1, bases above 36, forced hex prefix
    task automatic test_odd_bases();
        write_base(6'd1);
        send_str("001");
        write_base(6'd63);
        send_str("z{");
        write_base(6'd37);
        send_str("Az");
        send_char(CH_NUL, 1'b0);
        write_base(uitp_pkg::BASE_HEX);
        send_str("0XfF");
        send_char(CH_NUL, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering, then the sender pauses
    task automatic test_backpressure();
        int sent;
        sent = 0;
        write_base(uitp_pkg::BASE_DEC);
        hold_req = hold_req + 1;
        while (sent < 30)
            send_word(10, sent);
        wait_drained();
        while (sent < 50)
            send_word(10, sent);
    endtask

    // random words over several base settings, one stretch with no idling
    task automatic test_random_words();
        logic [uitp_pkg::BASE_W-1:0] bases[10];
        int sent;
        bases = '{6'd0, 6'd10, 6'd16, 6'd8, 6'd2, 6'd36, 6'd1, 6'd37, 6'd63,
                  uitp_pkg::BASE_W'($urandom_range(63, 0))};
        for (int k = 0; k < 10; k++)
        begin
            write_base(bases[k]);
            if (k == 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 24;
                rx_idle_pct = 24;
            end
            sent = 0;
            while (sent < 40)
            begin
                if ($urandom_range(9, 0) == 0)
                    send_noise();
                else
                    send_word(bases[k], sent);
            end
        end
        tx_idle_pct = 24;
        rx_idle_pct = 24;
    endtask

    // sequence
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_start();
        test_auto_base();
        test_overflow();
        test_odd_bases();
        test_backpressure();
        test_random_words();

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("unsigned_integer_text_parser_unit: match");
        else
            $display("unsigned_integer_text_parser_unit: mismatch");
        $finish;
    end

endmodule
